@@ hdl/mwm_pkg.sv @@
// Package for the mecanum wheel mixer: codes, widths, item and config types.
package mwm_pkg;

  localparam int VAL_W    = 18;  // signed wheel value width (exact body mix)
  localparam int MAG_W    = 17;  // wheel magnitude width
  localparam int DUTY_W   = 15;
  localparam int PROD_W   = MAG_W + DUTY_W;
  localparam int REM_W    = PROD_W + 1;
  localparam int Q_BITS   = DUTY_W;  // scaled magnitude never exceeds pwm_max
  localparam int NWHEEL   = 4;

  localparam logic [1:0] CMD_STOP = 2'd0;
  localparam logic [1:0] CMD_RAW  = 2'd1;
  localparam logic [1:0] CMD_TANK = 2'd2;
  localparam logic [1:0] CMD_BODY = 2'd3;

  localparam logic [1:0] REG_PWM_MAX    = 2'd0;
  localparam logic [1:0] REG_PWM_MIN    = 2'd1;
  localparam logic [1:0] REG_INVERT     = 2'd2;

  localparam logic [1:0] DIR_COAST = 2'd0;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_REV   = 2'd2;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_max;
    logic [DUTY_W-1:0] pwm_min;
    logic [3:0]        invert;
  } cfg_t;

  typedef struct packed {
    logic                         stop;
    logic                         body;
    logic [NWHEEL-1:0]            neg;
    logic [NWHEEL-1:0][MAG_W-1:0] mag;
  } item_t;

endpackage

@@ hdl/mecanum_wheel_mixer.sv @@
// Top level of the mecanum wheel mixer: config registers, front end, queue and back end.
//
// The mixer turns one drive command into a PWM duty and a direction code for each of
// four mecanum wheels. It takes one command per clock cycle and keeps taking them while
// results are stalled, until its small internal queue and pipeline fill. A command's
// transaction passes nineteen registers, the first loaded at the edge that accepts it:
// one in the front end, one in the queue, and 17 in the back end, whose length is set
// by the normalization divider that resolves one quotient bit per stage for all four
// wheels at once (15 stages), plus a product stage and an output stage. Configuration
// writes should only be made while no command is in flight.
module mecanum_wheel_mixer import mwm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // raw_front_left, raw_front_right, raw_rear_left, raw_rear_right,
  // left_speed, right_speed, forward, strafe, yaw (16 bits each, lowest first)
  input  logic [143:0] s_tdata,
  // command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // duty_front_left, duty_front_right, duty_rear_left, duty_rear_right (15 bits each),
  // dir_front_left, dir_front_right, dir_rear_left, dir_rear_right (2 bits each),
  // then four zero bits
  output logic [71:0]  m_tdata
);

  cfg_t  cfg;
  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_ready;
  item_t q_item;

  // The configuration registers are written directly; index 3 is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_max <= 15'd1000;
      cfg.pwm_min <= '0;
      cfg.invert  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_MAX: cfg.pwm_max <= cfg_data;
        REG_PWM_MIN: cfg.pwm_min <= cfg_data;
        REG_INVERT:  cfg.invert  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The front end resolves the command into signed wheel values.
  mwm_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(s_tuser), .in_data(s_tdata),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  // The queue lets the front end keep accepting while the back end is stalled.
  mwm_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  // The back end normalizes body commands and forms duty and direction.
  mwm_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule

@@ hdl/mwm_front.sv @@
// Front end: accepts commands, forms the four signed wheel values, splits sign and magnitude.
module mwm_front import mwm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_cmd,
  input  logic [143:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output item_t        out_item
);

  logic                   valid;
  item_t                  item;
  item_t                  item_next;
  logic signed [VAL_W-1:0] w [NWHEEL];
  logic signed [VAL_W-1:0] f, s, y, l, r;

  function automatic logic signed [VAL_W-1:0] pol(input logic signed [VAL_W-1:0] v,
                                                  input logic inv);
    return inv ? -v : v;
  endfunction

  always_comb begin
    // strafe and yaw sit in the two top words
    s = VAL_W'($signed(in_data[127:112]));
    f = VAL_W'($signed(in_data[111:96]));
    y = VAL_W'($signed(in_data[143:128]));
    l = VAL_W'($signed(in_data[79:64]));
    r = VAL_W'($signed(in_data[95:80]));
    case (in_cmd)
      CMD_RAW: begin
        for (int i = 0; i < NWHEEL; i++)
          w[i] = VAL_W'($signed(in_data[16*i +: 16]));
      end
      CMD_TANK: begin
        w[0] = pol(l, cfg.invert[0]);
        w[1] = pol(r, cfg.invert[1]);
        w[2] = pol(l, cfg.invert[2]);
        w[3] = pol(r, cfg.invert[3]);
      end
      default: begin
        w[0] = pol(f + s + y, cfg.invert[0]);
        w[1] = pol(f - s - y, cfg.invert[1]);
        w[2] = pol(f - s + y, cfg.invert[2]);
        w[3] = pol(f + s - y, cfg.invert[3]);
      end
    endcase
    item_next.stop = (in_cmd == CMD_STOP);
    item_next.body = (in_cmd == CMD_BODY);
    for (int i = 0; i < NWHEEL; i++) begin
      item_next.neg[i] = w[i][VAL_W-1];
      item_next.mag[i] = w[i][VAL_W-1] ? MAG_W'(-w[i]) : MAG_W'(w[i]);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

@@ hdl/mwm_queue.sv @@
// Two-entry queue between the front end and the scaling back end.
module mwm_queue import mwm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

endmodule

@@ hdl/mwm_back.sv @@
// Back end: normalization by a pipelined restoring divider, then saturation and minimum duty.
module mwm_back import mwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [71:0] out_data
);

  typedef struct packed {
    logic                          valid;
    item_t                         it;
    logic                          scale;
    logic [MAG_W-1:0]              mx;
    logic [NWHEEL-1:0][REM_W-1:0]  rem;
    logic [NWHEEL-1:0][Q_BITS-1:0] q;
  } stage_t;

  stage_t           stg [Q_BITS+1];
  stage_t           head;
  logic             adv;
  logic             ovalid;
  logic [71:0]      odata;
  logic [71:0]      odata_next;
  logic [MAG_W-1:0] m01, m23;

  assign adv       = !ovalid || out_ready;
  assign in_ready  = adv;
  assign out_valid = ovalid;
  assign out_data  = odata;

  // Stage 0: largest magnitude and the products magnitude * pwm_max.
  always_comb begin
    m01 = (in_item.mag[0] > in_item.mag[1]) ? in_item.mag[0] : in_item.mag[1];
    m23 = (in_item.mag[2] > in_item.mag[3]) ? in_item.mag[2] : in_item.mag[3];
    head.valid = in_valid;
    head.it    = in_item;
    head.mx    = (m01 > m23) ? m01 : m23;
    head.scale = in_item.body && (head.mx > MAG_W'(cfg.pwm_max));
    for (int i = 0; i < NWHEEL; i++) begin
      head.rem[i] = REM_W'(PROD_W'(in_item.mag[i]) * PROD_W'(cfg.pwm_max));
      head.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else if (adv) begin
      stg[0].valid <= head.valid;
    end
    if (adv) begin
      stg[0].it    <= head.it;
      stg[0].scale <= head.scale;
      stg[0].mx    <= head.mx;
      stg[0].rem   <= head.rem;
      stg[0].q     <= head.q;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    localparam int B = Q_BITS - 1 - k;
    stage_t           nxt;
    logic [REM_W-1:0] sh;
    always_comb begin
      nxt = stg[k];
      sh  = REM_W'(stg[k].mx) << B;
      for (int i = 0; i < NWHEEL; i++) begin
        if (stg[k].rem[i] >= sh) begin
          nxt.rem[i]  = stg[k].rem[i] - sh;
          nxt.q[i][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k+1].valid <= 1'b0;
      end else if (adv) begin
        stg[k+1].valid <= nxt.valid;
      end
      if (adv) begin
        stg[k+1].it    <= nxt.it;
        stg[k+1].scale <= nxt.scale;
        stg[k+1].mx    <= nxt.mx;
        stg[k+1].rem   <= nxt.rem;
        stg[k+1].q     <= nxt.q;
      end
    end
  end

  // Final stage: pick the scaled or plain magnitude, clamp, raise to minimum, set direction.
  always_comb begin
    logic [MAG_W-1:0]  v;
    logic [DUTY_W-1:0] d;
    logic [1:0]        dir;
    odata_next = '0;
    for (int i = 0; i < NWHEEL; i++) begin
      v = stg[Q_BITS].scale ? MAG_W'(stg[Q_BITS].q[i]) : stg[Q_BITS].it.mag[i];
      d = (v > MAG_W'(cfg.pwm_max)) ? cfg.pwm_max : DUTY_W'(v);
      if (d != '0 && d < cfg.pwm_min) d = cfg.pwm_min;
      if (stg[Q_BITS].it.stop) begin
        d   = '0;
        dir = DIR_COAST;
      end else if (stg[Q_BITS].it.neg[i] && v != '0) begin
        dir = DIR_REV;
      end else begin
        dir = DIR_FWD;
      end
      odata_next[DUTY_W*i +: DUTY_W] = d;
      odata_next[4*DUTY_W + 2*i +: 2] = dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= stg[Q_BITS].valid;
    end
    if (adv) begin
      odata <= odata_next;
    end
  end

endmodule

@@ hdl/mwm_checker.sv @@
// Port-level checker for the mecanum wheel mixer and its bind statement.
module mwm_checker import mwm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[61:60] != 2'd3 && m_tdata[63:62] != 2'd3 &&
                 m_tdata[65:64] != 2'd3 && m_tdata[67:66] != 2'd3)
    else $error("undefined direction code");

  a_coast: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[61:60] == DIR_COAST |->
      m_tdata[59:0] == '0 && m_tdata[67:62] == '0)
    else $error("coast with nonzero duty or mixed directions");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ tb/sv/mecanum_wheel_mixer_tb.sv @@
// Self-checking testbench for the mecanum wheel mixer.
module mecanum_wheel_mixer_tb;
  import mwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The four wheel results: duty and direction code of each wheel.
  typedef struct packed {
    logic [3:0][1:0]  dir;
    logic [3:0][14:0] duty;
  } wheel_set_t;

  // A drive command as the sender offers it.
  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] f [9];
  } drive_cmd_t;

  // The scoreboard keeps its own copy of the three registers and predicts the
  // four wheel outputs of every accepted command transaction.
  class mixer_scoreboard;
    int unsigned    pwm_max;
    int unsigned    pwm_min;
    logic [3:0]     invert;
    wheel_set_t     pending[$];
    int             errors;
    int             checked;

    function void set_reg(logic [1:0] idx, logic [14:0] val);
      if (idx == REG_PWM_MAX) pwm_max = val;
      else if (idx == REG_PWM_MIN) pwm_min = val;
      else if (idx == REG_INVERT) invert = val[3:0];
    endfunction

    function void note_command(drive_cmd_t c);
      longint     w [4];
      longint     mx, a, m;
      wheel_set_t r;
      r = '0;
      if (c.cmd != CMD_STOP) begin
        if (c.cmd == CMD_RAW) begin
          for (int i = 0; i < 4; i++) w[i] = c.f[i];
        end else if (c.cmd == CMD_TANK) begin
          w[0] = c.f[4]; w[1] = c.f[5]; w[2] = c.f[4]; w[3] = c.f[5];
        end else begin
          w[0] = longint'(c.f[6]) + c.f[7] + c.f[8];
          w[1] = longint'(c.f[6]) - c.f[7] - c.f[8];
          w[2] = longint'(c.f[6]) - c.f[7] + c.f[8];
          w[3] = longint'(c.f[6]) + c.f[7] - c.f[8];
        end
        if (c.cmd != CMD_RAW)
          for (int i = 0; i < 4; i++) if (invert[i]) w[i] = -w[i];
        if (c.cmd == CMD_BODY) begin
          mx = 0;
          for (int i = 0; i < 4; i++) begin
            a = w[i] < 0 ? -w[i] : w[i];
            if (a > mx) mx = a;
          end
          // SystemVerilog division truncates toward zero, as required.
          if (mx > pwm_max)
            for (int i = 0; i < 4; i++) w[i] = (w[i] * longint'(pwm_max)) / mx;
        end
        for (int i = 0; i < 4; i++) begin
          m = w[i] < 0 ? -w[i] : w[i];
          if (m > pwm_max) m = pwm_max;
          if (m > 0 && m < pwm_min) m = pwm_min;
          r.duty[i] = m[14:0];
          r.dir[i] = w[i] >= 0 ? DIR_FWD : DIR_REV;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [71:0] data);
      wheel_set_t got, exp;
      got = data[67:0];
      if (pending.size() == 0) begin
        $error("result with no command pending: %h", data);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      for (int i = 0; i < 4; i++) begin
        if (got.duty[i] !== exp.duty[i]) begin
          $error("duty wheel %0d: expected %0d actual %0d", i, exp.duty[i], got.duty[i]);
          errors++;
        end
        if (got.dir[i] !== exp.dir[i]) begin
          $error("dir wheel %0d: expected %0d actual %0d", i, exp.dir[i], got.dir[i]);
          errors++;
        end
      end
      if (data[71:68] !== 4'b0) begin
        $error("pad bits: expected 0 actual %h", data[71:68]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [14:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;

  mecanum_wheel_mixer dut (.*);

  always #2 clk = ~clk;

  mixer_scoreboard sb;
  int  send_idle_pct;   // chance, in percent, that the sender skips a cycle
  int  recv_idle_pct;   // chance that the receiver deasserts tready
  bit  hold_off;        // long receiver stall for back pressure
  int  sent;
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 400000;

  // Every accepted output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Register write; only made while nothing is in flight. The enable is
  // dropped again between writes so that writes never share a time step.
  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Wait until every predicted result has been checked, plus the pipeline depth.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Offer one command and hold it until the transaction is accepted. The valid
  // stays high between back-to-back commands, so it is set exactly once per step.
  task automatic send_command(drive_cmd_t c);
    logic [143:0] d;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) d[16*i +: 16] = c.f[i];
    s_tvalid <= 1'b1;
    s_tuser <= c.cmd;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_command(c);
    sent++;
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Random field value, weighted toward the extremes and small magnitudes.
  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(7))
      0: rand_field = 16'sh8000;
      1: rand_field = 16'sh7fff;
      2: rand_field = 16'($urandom_range(2000) - 1000);
      3: rand_field = 16'($urandom_range(20) - 10);
      default: rand_field = 16'($urandom);
    endcase
  endfunction

  function automatic drive_cmd_t rand_command();
    drive_cmd_t c;
    c.cmd = 2'($urandom_range(3));
    for (int i = 0; i < 9; i++) c.f[i] = rand_field();
    return c;
  endfunction

  task automatic directed();
    drive_cmd_t c;
    for (int k = 0; k < 20; k++) begin
      c.cmd = 2'(k % 4);
      for (int i = 0; i < 9; i++)
        case (k / 4)
          0: c.f[i] = 16'sh8000;
          1: c.f[i] = 16'sh7fff;
          2: c.f[i] = 16'sh0000;
          3: c.f[i] = (i % 2) ? 16'shffff : 16'sh0001;
          default: c.f[i] = (i % 2) ? 16'sh8000 : 16'sh7fff;
        endcase
      send_command(c);
    end
    idle_sender();
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) send_command(rand_command());
    idle_sender();
  endtask

  // Register settings visited; each phase runs the random part under one.
  int unsigned max_set [6] = '{1000, 32767, 1, 0, 255, 20000};
  int unsigned min_set [6] = '{0, 32767, 0, 50, 300, 10};
  int unsigned inv_set [6] = '{0, 15, 5, 10, 3, 12};

  initial begin
    sb = new();
    sb.pwm_max = 1000;
    sb.pwm_min = 0;
    sb.invert = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners under reset values, then with inversion and a high minimum.
    directed();
    drain();
    write_reg(REG_INVERT, 15'd15);
    write_reg(REG_PWM_MIN, 15'd999);
    directed();
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_PWM_MAX, 15'(max_set[p]));
      write_reg(REG_PWM_MIN, 15'(min_set[p]));
      write_reg(REG_INVERT, 15'(inv_set[p]));
      send_idle_pct = (p < 2) ? 27 : (p < 4) ? 84 : 0;
      recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 27 : 0;
      if (p == 4) begin
        // Back pressure: the receiver stalls while the sender keeps offering.
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
          random_phase(100);
        join
      end
      random_phase(252);
      drain();
    end

    $display("Sent %0d commands over eight register settings; %0d results compared.",
             sent, sb.checked);
    $display("Covered stop, raw, tank and body commands with stalls on both sides.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
